[hdl/mi_pkg.sv]
package mi_pkg;

  localparam int WIDTH = 32;
  // signed coefficient width: |t| never exceeds the modulus
  localparam int TW = WIDTH + 1;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_RED_WAIT,
    ST_CHECK,
    ST_DIV_WAIT,
    ST_MUL,
    ST_UPD,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic load;       // capture operand and modulus
    logic div_start;  // launch divider
    logic div_loop;   // divider operands: 1 = r0 / r1, 0 = value / modulus
    logic init;       // seed remainders and coefficients after reduction
    logic mul;        // register quotient times t1
    logic upd;        // advance one euclid step
    logic out_load;   // write result register
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic r1_zero;
    logic m_zero;
  } status_t;

endpackage

[hdl/mi_div.sv]
module mi_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [mi_pkg::WIDTH-1:0] dividend,
  input  logic [mi_pkg::WIDTH-1:0] divisor,
  output logic                     done,
  output logic [mi_pkg::WIDTH-1:0] quot,
  output logic [mi_pkg::WIDTH-1:0] rem
);

  logic [mi_pkg::WIDTH-1:0] quot_r, quot_nxt;
  logic [mi_pkg::WIDTH-1:0] rem_r, rem_nxt;
  logic [mi_pkg::WIDTH-1:0] dsr_r, dsr_nxt;
  logic [mi_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [mi_pkg::WIDTH:0]   rem_sh;
  logic [mi_pkg::WIDTH:0]   rem_diff;
  logic                     fits;

  // restoring division, one quotient bit per cycle
  assign rem_sh   = {rem_r, quot_r[mi_pkg::WIDTH-1]};
  assign fits     = rem_sh >= {1'b0, dsr_r};
  assign rem_diff = rem_sh - {1'b0, dsr_r};

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = mi_pkg::CNT_W'(mi_pkg::WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = {quot_r[mi_pkg::WIDTH-2:0], fits};
      rem_nxt  = fits ? rem_diff[mi_pkg::WIDTH-1:0] : rem_sh[mi_pkg::WIDTH-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == mi_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

[hdl/mi_dp.sv]
module mi_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [mi_pkg::WIDTH-1:0] cfg_data,
  input  logic [mi_pkg::WIDTH-1:0] in_value,
  input  mi_pkg::cmd_t             cmd,
  output mi_pkg::status_t          status,
  output logic [mi_pkg::WIDTH-1:0] out_inverse,
  output logic                     out_no_inverse
);

  localparam int W  = mi_pkg::WIDTH;
  localparam int TW = mi_pkg::TW;

  logic [W-1:0]    mod_r;
  logic [W-1:0]    a_r, m_r, r0_r, r1_r;
  logic [TW-1:0]   t0_r, t1_r, prod_r;
  logic [W-1:0]    inv_r;
  logic            noinv_r;
  logic [W-1:0]    div_dvd, div_dsr, div_quot, div_rem;
  logic            div_done;
  logic [TW-1:0]   prod_full;
  logic [TW-1:0]   q_ext;
  logic [TW-1:0]   inv_fix;
  logic            ok;

  assign div_dvd = cmd.div_loop ? r0_r : a_r;
  assign div_dsr = cmd.div_loop ? r1_r : m_r;

  mi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // low TW bits of the product are exact in two's complement
  assign q_ext     = {1'b0, div_quot};
  assign prod_full = q_ext * t1_r;

  // at gcd 1 the final coefficient lies within half the modulus, so one fold suffices
  assign inv_fix = t0_r[TW-1] ? (t0_r + {1'b0, m_r}) : t0_r;
  assign ok      = (r0_r == W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= W'(1);
    end else if (cfg_we) begin
      mod_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r  <= in_value;
      m_r  <= mod_r;
      r0_r <= mod_r;
    end
    if (cmd.init) begin
      r0_r <= m_r;
      r1_r <= div_rem;
      t0_r <= '0;
      t1_r <= TW'(1);
    end
    if (cmd.mul) begin
      prod_r <= prod_full;
    end
    if (cmd.upd) begin
      r0_r <= r1_r;
      r1_r <= div_rem;
      t0_r <= t1_r;
      t1_r <= t0_r - prod_r;
    end
    if (cmd.out_load) begin
      inv_r   <= ok ? inv_fix[W-1:0] : '0;
      noinv_r <= !ok;
    end
  end

  assign status.div_done = div_done;
  assign status.r1_zero  = (r1_r == '0);
  assign status.m_zero   = (m_r == '0);

  assign out_inverse    = inv_r;
  assign out_no_inverse = noinv_r;

endmodule

[hdl/mi_ctrl.sv]
module mi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  mi_pkg::status_t status,
  output mi_pkg::cmd_t    cmd
);

  mi_pkg::state_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mi_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      mi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mi_pkg::ST_RED;
        end
      end
      mi_pkg::ST_RED: begin
        if (status.m_zero) begin
          state_nxt = mi_pkg::ST_FINAL;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = mi_pkg::ST_RED_WAIT;
        end
      end
      mi_pkg::ST_RED_WAIT: begin
        if (status.div_done) begin
          cmd.init  = 1'b1;
          state_nxt = mi_pkg::ST_CHECK;
        end
      end
      mi_pkg::ST_CHECK: begin
        if (status.r1_zero) begin
          state_nxt = mi_pkg::ST_FINAL;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_loop  = 1'b1;
          state_nxt     = mi_pkg::ST_DIV_WAIT;
        end
      end
      mi_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          state_nxt = mi_pkg::ST_MUL;
        end
      end
      mi_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = mi_pkg::ST_UPD;
      end
      mi_pkg::ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = mi_pkg::ST_CHECK;
      end
      mi_pkg::ST_FINAL: begin
        // wait for the result slot to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = mi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mi_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input beat taken while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> (state_r == mi_pkg::ST_RED_WAIT || state_r == mi_pkg::ST_DIV_WAIT))
    else $error("divider done outside a wait state");

  a_load_to_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load lost");
`endif

endmodule

[hdl/modular_inverse.sv]
// channel  direction  signals                            beat when
// in       input      in_valid in_ready in_value         in_valid && in_ready
// out      output     out_valid out_ready out_inverse    out_valid && out_ready
//                     out_no_inverse
// cfg      input      cfg_we cfg_data                    cfg_we
//
// one item at a time: a reduction, then euclid steps, each a bit-serial division,
// then quotient times coefficient, then update, with entry and exit states around them.
// rst_n is synchronous; it empties the block and sets the modulus to 1.
// a waiting result holds the next result in the final state until it is taken;
// a new input beat is taken as soon as that result is loaded.
module modular_inverse (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [mi_pkg::WIDTH-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [mi_pkg::WIDTH-1:0] out_inverse,
  output logic                     out_no_inverse,
  input  logic                     cfg_we,
  input  logic [mi_pkg::WIDTH-1:0] cfg_data
);

  mi_pkg::cmd_t    cmd;
  mi_pkg::status_t status;

  mi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mi_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_value       (in_value),
    .cmd            (cmd),
    .status         (status),
    .out_inverse    (out_inverse),
    .out_no_inverse (out_no_inverse)
  );

endmodule

[sim/tb_top.sv]
module tb_top;

  typedef logic [mi_pkg::WIDTH-1:0] word_t;

  typedef struct packed {
    word_t inverse;
    logic  no_inverse;
  } inv_result_t;

  typedef struct packed {
    logic  set_mod;
    word_t modulus;
    word_t value;
    logic  typed;
    word_t inverse;
    logic  no_inverse;
  } dir_row_t;

  localparam int NUM_DIRECTED = 24;
  localparam int NUM_PHASES = 20;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int QUIET_PHASES = 3;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_PHASE = 6;
  localparam int PAUSE_PHASE = 3;
  localparam int DRAIN_CYCLES = 2000;

  // typed rows are read straight off the definition, the rest go through the predictor
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    // modulus one straight after reset
    '{1'b0, 32'd0,          32'd0,          1'b1, 32'd0,          1'b0},
    '{1'b0, 32'd0,          32'hFFFFFFFF,   1'b1, 32'd0,          1'b0},
    // modulus zero never has an inverse
    '{1'b1, 32'd0,          32'd5,          1'b1, 32'd0,          1'b1},
    '{1'b1, 32'd7,          32'd3,          1'b0, 32'd0,          1'b0},
    '{1'b0, 32'd7,          32'd0,          1'b1, 32'd0,          1'b1},
    '{1'b0, 32'd7,          32'd7,          1'b1, 32'd0,          1'b1},
    '{1'b0, 32'd7,          32'd1,          1'b1, 32'd1,          1'b0},
    '{1'b0, 32'd7,          32'd6,          1'b1, 32'd6,          1'b0},
    '{1'b0, 32'd7,          32'd10,         1'b0, 32'd0,          1'b0},
    '{1'b1, 32'd2,          32'd1,          1'b1, 32'd1,          1'b0},
    '{1'b0, 32'd2,          32'hFFFFFFFF,   1'b1, 32'd1,          1'b0},
    '{1'b0, 32'd2,          32'hFFFFFFFE,   1'b1, 32'd0,          1'b1},
    '{1'b1, 32'hFFFFFFFF,   32'hFFFFFFFE,   1'b1, 32'hFFFFFFFE,   1'b0},
    '{1'b0, 32'hFFFFFFFF,   32'd1,          1'b1, 32'd1,          1'b0},
    '{1'b0, 32'hFFFFFFFF,   32'd3,          1'b1, 32'd0,          1'b1},
    '{1'b0, 32'hFFFFFFFF,   32'd2,          1'b0, 32'd0,          1'b0},
    '{1'b0, 32'hFFFFFFFF,   32'hFFFFFFFF,   1'b1, 32'd0,          1'b1},
    '{1'b1, 32'h80000000,   32'h80000001,   1'b1, 32'd1,          1'b0},
    '{1'b0, 32'h80000000,   32'h7FFFFFFF,   1'b1, 32'h7FFFFFFF,   1'b0},
    '{1'b0, 32'h80000000,   32'h40000000,   1'b1, 32'd0,          1'b1},
    '{1'b1, 32'hFFFFFFFB,   32'h12345678,   1'b0, 32'd0,          1'b0},
    '{1'b0, 32'hFFFFFFFB,   32'hFFFFFFFA,   1'b1, 32'hFFFFFFFA,   1'b0},
    // consecutive fibonacci numbers: longest euclid chain
    '{1'b1, 32'd2971215073, 32'd1836311903, 1'b0, 32'd0,          1'b0},
    '{1'b0, 32'd2971215073, 32'hFFFFFFFF,   1'b0, 32'd0,          1'b0}
  };

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  word_t in_value;
  logic  out_valid;
  logic  out_ready;
  word_t out_inverse;
  logic  out_no_inverse;
  logic  cfg_we;
  word_t cfg_data;

  inv_result_t pending_results[$];
  word_t       cur_modulus;
  int          errors = 0;
  bit          idle_on;
  bit          hold_req;
  bit          hold_done;
  int          stall_left;
  inv_result_t got_res;
  inv_result_t want_res;
  inv_result_t row_res;
  dir_row_t    row;
  word_t       stim_value;

  modular_inverse i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inverse    (out_inverse),
    .out_no_inverse (out_no_inverse),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // extended euclid on (m, value mod m), coefficients wrap at 64 bits
  function automatic inv_result_t predict_inverse(word_t value, word_t m);
    logic [63:0] r0, r1, t0, t1, q, tmp;
    int          steps;
    inv_result_t res;
    res.inverse = '0;
    res.no_inverse = 1'b1;
    if (m == '0) return res;
    r0 = 64'(m);
    r1 = 64'(value) % 64'(m);
    t0 = 64'd0;
    t1 = 64'd1;
    steps = 0;
    while (steps < 2 * mi_pkg::WIDTH + 2 && r1 != 64'd0) begin
      q = r0 / r1;
      tmp = r0 - q * r1;
      r0 = r1;
      r1 = tmp;
      tmp = t0 - q * t1;
      t0 = t1;
      t1 = tmp;
      steps++;
    end
    if (r0 != 64'd1) return res;
    if (t0[63]) t0 = 64'(m) + t0;
    res.inverse = word_t'(t0 % 64'(m));
    res.no_inverse = 1'b0;
    return res;
  endfunction

  function automatic word_t pick_modulus();
    word_t m;
    case ($urandom_range(0, 7))
      0, 1, 2: m = $urandom_range(2, 65535);
      3:       m = $urandom_range(2, 255);
      4:       m = $urandom | 32'h80000000;
      5:       m = $urandom >> $urandom_range(0, 15);
      6: begin
        case ($urandom_range(0, 4))
          0:       m = 32'd1;
          1:       m = 32'd3;
          2:       m = 32'hFFFFFFFF;
          3:       m = 32'hFFFFFFFB;
          default: m = 32'h80000000;
        endcase
      end
      default: m = $urandom_range(2, 65535) | 32'd1;
    endcase
    if (m == '0) m = 32'd1;
    return m;
  endfunction

  function automatic word_t pick_value(word_t m);
    word_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = $urandom % m;
      7: begin
        case ($urandom_range(0, 2))
          0:       v = m - 32'd1;
          1:       v = m + 32'd1;
          default: v = m;
        endcase
      end
      8: v = m * $urandom_range(0, 32'hFFFFFFFF / m);
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 32'd0;
          1:       v = 32'd1;
          2:       v = 32'hFFFFFFFF;
          default: v = 32'h80000000;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_value(word_t v, inv_result_t res);
    logic got;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    got = 1'b0;
    while (!got) begin
      @(negedge clk);
      got = in_ready;
      @(posedge clk);
    end
    pending_results = {pending_results, res};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_modulus(word_t m);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_modulus = m;
  endtask

  // receiver: random stall bursts, plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_done <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      stall_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // values are stable at the falling edge, so this sees the beat of the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_res.inverse = out_inverse;
      got_res.no_inverse = out_no_inverse;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: inverse %h no_inverse %b",
               got_res.inverse, got_res.no_inverse);
        errors++;
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.inverse !== want_res.inverse) begin
          $error("inverse: expected %h, got %h", want_res.inverse, got_res.inverse);
          errors++;
        end
        if (got_res.no_inverse !== want_res.no_inverse) begin
          $error("no_inverse: expected %b, got %b", want_res.no_inverse, got_res.no_inverse);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    hold_req = 1'b0;
    idle_on = 1'b1;
    cur_modulus = 32'd1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.set_mod) begin
        wait_drained();
        set_modulus(row.modulus);
      end
      if (row.typed) begin
        row_res = '{row.inverse, row.no_inverse};
      end else begin
        row_res = predict_inverse(row.value, cur_modulus);
      end
      send_value(row.value, row_res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      idle_on = (p < NUM_PHASES - QUIET_PHASES) && ($urandom_range(0, 4) != 0);
      // small modulus for the long hold so the block fills up quickly
      if (p == HOLD_PHASE) begin
        set_modulus($urandom_range(3, 5000));
        hold_req = 1'b1;
      end else begin
        set_modulus(pick_modulus());
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) wait_drained();
        stim_value = pick_value(cur_modulus);
        send_value(stim_value, predict_inverse(stim_value, cur_modulus));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(12 * 12_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
hdl/mi_pkg.sv
hdl/mi_div.sv
hdl/mi_dp.sv
hdl/mi_ctrl.sv
hdl/modular_inverse.sv
sim/tb_top.sv
